FILE: sv/qxm_pkg.sv
// Package for the quad X-frame motor mixer: payload structs, configuration
// register indexes and reset values, and the fixed-point constants of the
// battery compensation. No dependencies.
package qxm_pkg;

    // Field widths.
    localparam int PulseW  = 12;
    localparam int MixW    = 15;   // signed mixed pulse, -6144 .. 10239
    localparam int FactorW = 13;   // compensation factor, 3500 .. 7594
    localparam int NumW    = 27;   // unsigned product of pulse and factor
    localparam int QuotW   = 15;   // compensated pulse before clamping
    localparam int CfgIdxW = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_STICK_LOW    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_STICK_HIGH   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_THROTTLE_CAP = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MOTOR_IDLE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MOTOR_MAX    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MOTOR_OFF    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_BATTERY_FULL = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_BATTERY_MIN  = 3'd7;

    // Configuration reset values.
    localparam logic [PulseW-1:0] RST_STICK_LOW    = 12'd1050;
    localparam logic [PulseW-1:0] RST_STICK_HIGH   = 12'd1950;
    localparam logic [PulseW-1:0] RST_THROTTLE_CAP = 12'd1800;
    localparam logic [PulseW-1:0] RST_MOTOR_IDLE   = 12'd1100;
    localparam logic [PulseW-1:0] RST_MOTOR_MAX    = 12'd2000;
    localparam logic [PulseW-1:0] RST_MOTOR_OFF    = 12'd1000;
    localparam logic [PulseW-1:0] RST_BATTERY_FULL = 12'd1240;
    localparam logic [PulseW-1:0] RST_BATTERY_MIN  = 12'd800;

    // Compensation divides by 3500. The divide is done as a shift by two and
    // an exact reciprocal multiply by 1/875 over a 25-bit dividend.
    localparam int CompDivisor = 3500;
    localparam logic [FactorW-1:0] COMP_BASE = FactorW'(CompDivisor);
    localparam longint CompQuarter = CompDivisor / 4;
    localparam int RecipShift = 35;
    localparam int RecipW = 26;
    localparam logic [RecipW-1:0] RECIP_MULT =
        RecipW'(((longint'(1) << RecipShift) + CompQuarter - 1) / CompQuarter);

    // Input transaction.
    typedef struct packed {
        logic [PulseW-1:0]        throttle_stick;
        logic [PulseW-1:0]        yaw_stick;
        logic signed [PulseW-1:0] pid_roll;
        logic signed [PulseW-1:0] pid_pitch;
        logic signed [PulseW-1:0] pid_yaw;
        logic [PulseW-1:0]        battery_level;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [PulseW-1:0] motor_front_left;
        logic [PulseW-1:0] motor_front_right;
        logic [PulseW-1:0] motor_back_left;
        logic [PulseW-1:0] motor_back_right;
        logic              armed_now;
        logic              clear_integrators;
    } t_out_item;

    // Configuration register file.
    typedef struct packed {
        logic [PulseW-1:0] stick_low;
        logic [PulseW-1:0] stick_high;
        logic [PulseW-1:0] throttle_cap;
        logic [PulseW-1:0] motor_idle;
        logic [PulseW-1:0] motor_max;
        logic [PulseW-1:0] motor_off;
        logic [PulseW-1:0] battery_full;
        logic [PulseW-1:0] battery_min;
    } t_cfg;

    // Arming flags carried down the pipeline.
    typedef struct packed {
        logic armed;
        logic clr;
    } t_flags;

    // Stage load enables handed to each motor lane.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_lane_en;

endpackage

FILE: sv/qxm_pulse_lane.sv
// One motor lane of the mixer: battery compensation multiply, reciprocal
// divide by 3500, and idle/max clamping or the off pulse while disarmed, over
// three pipeline stages. Depends on qxm_pkg.
module qxm_pulse_lane (
    input  logic                              i_clk,
    input  qxm_pkg::t_lane_en                 i_en,
    input  logic signed [qxm_pkg::MixW-1:0]   i_pulse,
    input  logic [qxm_pkg::FactorW-1:0]       i_factor,
    input  logic                              i_armed,
    input  logic [qxm_pkg::PulseW-1:0]        i_motor_idle,
    input  logic [qxm_pkg::PulseW-1:0]        i_motor_max,
    input  logic [qxm_pkg::PulseW-1:0]        i_motor_off,
    output logic [qxm_pkg::PulseW-1:0]        o_pulse
);

    localparam int ProdW = qxm_pkg::RecipW + qxm_pkg::NumW - 2;

    logic [qxm_pkg::NumW-1:0]    n_num;
    logic [qxm_pkg::NumW-1:0]    r_num;
    logic                        r_neg2;
    logic [ProdW-1:0]            w_prod;
    logic [qxm_pkg::QuotW-1:0]   n_quot;
    logic [qxm_pkg::QuotW-1:0]   r_quot;
    logic                        r_neg3;
    logic [qxm_pkg::QuotW-1:0]   w_raised;
    logic [qxm_pkg::QuotW-1:0]   w_limited;
    logic [qxm_pkg::PulseW-1:0]  n_pulse;
    logic [qxm_pkg::PulseW-1:0]  r_pulse;

    // Stage 2: magnitude of a non-negative pulse times the factor.
    // A negative pulse is always raised to the idle value, so only its sign is kept.
    assign n_num = {{(qxm_pkg::NumW-qxm_pkg::MixW+1){1'b0}}, i_pulse[qxm_pkg::MixW-2:0]}
                 * {{(qxm_pkg::NumW-qxm_pkg::FactorW){1'b0}}, i_factor};

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_num  <= n_num;
            r_neg2 <= i_pulse[qxm_pkg::MixW-1];
        end
    end

    // Stage 3: floor division by 3500 as (num >> 2) * M >> 35.
    assign w_prod = {{(ProdW-qxm_pkg::NumW+2){1'b0}}, r_num[qxm_pkg::NumW-1:2]}
                  * {{(ProdW-qxm_pkg::RecipW){1'b0}}, qxm_pkg::RECIP_MULT};
    assign n_quot = w_prod[qxm_pkg::RecipShift+qxm_pkg::QuotW-1:qxm_pkg::RecipShift];

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_quot <= n_quot;
            r_neg3 <= r_neg2;
        end
    end

    // Stage 4: raise to idle, then lower to max; off pulse while disarmed.
    always_comb begin
        if (r_neg3 || (r_quot < {3'd0, i_motor_idle})) begin
            w_raised = {3'd0, i_motor_idle};
        end else begin
            w_raised = r_quot;
        end
        if (w_raised > {3'd0, i_motor_max}) begin
            w_limited = {3'd0, i_motor_max};
        end else begin
            w_limited = w_raised;
        end
        n_pulse = i_armed ? w_limited[qxm_pkg::PulseW-1:0] : i_motor_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_pulse <= n_pulse;
        end
    end

    assign o_pulse = r_pulse;

endmodule

FILE: sv/quad_x_motor_mixer_with_arming.sv
// Top level of the quad X-frame motor mixer with stick-gesture arming.
// Holds the configuration registers, the arm state and the pipeline control,
// and instantiates four qxm_pulse_lane blocks. Depends on qxm_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall / i_in_data carry one control tick
//   per transaction. Output channel: o_out_valid / i_out_stall / o_out_data
//   carry the four motor pulses and the arm flags for that tick.
//   Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
//   at that clock edge; write only while no tick is in flight.
//   Pipeline: a tick is registered in stage 0 at the edge that accepts it and then
//   passes the mix, compensation multiply, reciprocal divide and clamp stages.
//   Throughput: one transaction per cycle while the output is not stalled, set by
//   the five-stage pipeline, which holds one tick in every stage.
//   The arm state is updated at the edge that accepts the tick, so gestures
//   take effect in arrival order.
//   Reset: clears the pipeline, disarms the motors and loads the default
//   register values.
//   Stall: a stalled result holds on the output; the stages behind it keep
//   filling, and o_in_stall rises once every stage holds a tick.
module quad_x_motor_mixer_with_arming (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  qxm_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output qxm_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [qxm_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [qxm_pkg::PulseW-1:0]     i_cfg_data
);

    localparam int Lanes = 4;

    qxm_pkg::t_cfg      r_cfg;
    logic               r_armed;
    logic               n_armed;
    logic               n_clr;
    logic               w_accept;

    logic [4:0]         r_valid;
    logic [4:0]         w_ready;

    qxm_pkg::t_in_item  r_item0;
    qxm_pkg::t_flags    r_flg0;
    qxm_pkg::t_flags    r_flg1;
    qxm_pkg::t_flags    r_flg2;
    qxm_pkg::t_flags    r_flg3;
    qxm_pkg::t_flags    r_flg4;

    logic [qxm_pkg::PulseW-1:0]        w_thr;
    logic signed [qxm_pkg::MixW-1:0]   w_t;
    logic signed [qxm_pkg::MixW-1:0]   w_roll;
    logic signed [qxm_pkg::MixW-1:0]   w_pitch;
    logic signed [qxm_pkg::MixW-1:0]   w_yaw;
    logic signed [qxm_pkg::MixW-1:0]   n_mix [Lanes];
    logic signed [qxm_pkg::MixW-1:0]   r_mix1 [Lanes];
    logic [qxm_pkg::PulseW-1:0]        w_drop;
    logic                              w_comp;
    logic [qxm_pkg::FactorW-1:0]       n_factor;
    logic [qxm_pkg::FactorW-1:0]       r_factor1;

    qxm_pkg::t_lane_en                 w_lane_en;
    logic [qxm_pkg::PulseW-1:0]        w_pulse [Lanes];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_low    <= qxm_pkg::RST_STICK_LOW;
            r_cfg.stick_high   <= qxm_pkg::RST_STICK_HIGH;
            r_cfg.throttle_cap <= qxm_pkg::RST_THROTTLE_CAP;
            r_cfg.motor_idle   <= qxm_pkg::RST_MOTOR_IDLE;
            r_cfg.motor_max    <= qxm_pkg::RST_MOTOR_MAX;
            r_cfg.motor_off    <= qxm_pkg::RST_MOTOR_OFF;
            r_cfg.battery_full <= qxm_pkg::RST_BATTERY_FULL;
            r_cfg.battery_min  <= qxm_pkg::RST_BATTERY_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qxm_pkg::CFG_STICK_LOW:    r_cfg.stick_low    <= i_cfg_data;
                qxm_pkg::CFG_STICK_HIGH:   r_cfg.stick_high   <= i_cfg_data;
                qxm_pkg::CFG_THROTTLE_CAP: r_cfg.throttle_cap <= i_cfg_data;
                qxm_pkg::CFG_MOTOR_IDLE:   r_cfg.motor_idle   <= i_cfg_data;
                qxm_pkg::CFG_MOTOR_MAX:    r_cfg.motor_max    <= i_cfg_data;
                qxm_pkg::CFG_MOTOR_OFF:    r_cfg.motor_off    <= i_cfg_data;
                qxm_pkg::CFG_BATTERY_FULL: r_cfg.battery_full <= i_cfg_data;
                qxm_pkg::CFG_BATTERY_MIN:  r_cfg.battery_min  <= i_cfg_data;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or the next one moves.
    assign w_ready[4] = !r_valid[4] || !i_out_stall;
    assign w_ready[3] = !r_valid[3] || w_ready[4];
    assign w_ready[2] = !r_valid[2] || w_ready[3];
    assign w_ready[1] = !r_valid[1] || w_ready[2];
    assign w_ready[0] = !r_valid[0] || w_ready[1];
    assign o_in_stall = !w_ready[0];
    assign w_accept   = i_in_valid && w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) r_valid[0] <= i_in_valid;
            if (w_ready[1]) r_valid[1] <= r_valid[0];
            if (w_ready[2]) r_valid[2] <= r_valid[1];
            if (w_ready[3]) r_valid[3] <= r_valid[2];
            if (w_ready[4]) r_valid[4] <= r_valid[3];
        end
    end

    // Arming gestures, evaluated on the incoming transaction; disarm wins.
    always_comb begin
        n_armed = r_armed;
        n_clr   = 1'b0;
        if ((i_in_data.yaw_stick < r_cfg.stick_low)
                && (i_in_data.throttle_stick < r_cfg.stick_low)) begin
            n_armed = 1'b0;
            n_clr   = 1'b1;
        end else if ((i_in_data.yaw_stick > r_cfg.stick_high)
                && (i_in_data.throttle_stick < r_cfg.stick_low)) begin
            n_armed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (w_accept) begin
            r_armed <= n_armed;
        end
    end

    // Stage 0: input register.
    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_item0      <= i_in_data;
            r_flg0.armed <= n_armed;
            r_flg0.clr   <= n_clr;
        end
    end

    // Stage 1: throttle cap, X-frame mix and compensation factor.
    always_comb begin
        w_thr   = (r_item0.throttle_stick > r_cfg.throttle_cap)
                ? r_cfg.throttle_cap : r_item0.throttle_stick;
        w_t     = {3'd0, w_thr};
        w_roll  = {{3{r_item0.pid_roll[qxm_pkg::PulseW-1]}}, r_item0.pid_roll};
        w_pitch = {{3{r_item0.pid_pitch[qxm_pkg::PulseW-1]}}, r_item0.pid_pitch};
        w_yaw   = {{3{r_item0.pid_yaw[qxm_pkg::PulseW-1]}}, r_item0.pid_yaw};
        n_mix[0] = w_t - w_pitch - w_roll + w_yaw;   // front left
        n_mix[1] = w_t - w_pitch + w_roll - w_yaw;   // front right
        n_mix[2] = w_t + w_pitch - w_roll - w_yaw;   // back left
        n_mix[3] = w_t + w_pitch + w_roll + w_yaw;   // back right
        w_comp   = (r_item0.battery_level < r_cfg.battery_full)
                && (r_item0.battery_level > r_cfg.battery_min);
        w_drop   = r_cfg.battery_full - r_item0.battery_level;
        // Without compensation the factor is the divisor itself, which leaves
        // the pulse unchanged.
        n_factor = w_comp ? (qxm_pkg::COMP_BASE + {1'b0, w_drop}) : qxm_pkg::COMP_BASE;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[1]) begin
            for (int i = 0; i < Lanes; i++) begin
                r_mix1[i] <= n_mix[i];
            end
            r_factor1 <= n_factor;
            r_flg1    <= r_flg0;
        end
    end

    // Stages 2 to 4 flags; the pulse work happens in the lanes.
    always_ff @(posedge i_clk) begin
        if (w_ready[2]) r_flg2 <= r_flg1;
        if (w_ready[3]) r_flg3 <= r_flg2;
        if (w_ready[4]) r_flg4 <= r_flg3;
    end

    assign w_lane_en.s2 = w_ready[2];
    assign w_lane_en.s3 = w_ready[3];
    assign w_lane_en.s4 = w_ready[4];

    // Four motor lanes.
    for (genvar g = 0; g < Lanes; g++) begin : g_lane
        qxm_pulse_lane u_lane (
            .i_clk        (i_clk),
            .i_en         (w_lane_en),
            .i_pulse      (r_mix1[g]),
            .i_factor     (r_factor1),
            .i_armed      (r_flg3.armed),
            .i_motor_idle (r_cfg.motor_idle),
            .i_motor_max  (r_cfg.motor_max),
            .i_motor_off  (r_cfg.motor_off),
            .o_pulse      (w_pulse[g])
        );
    end

    // Output transaction.
    assign o_out_valid                  = r_valid[4];
    assign o_out_data.motor_front_left  = w_pulse[0];
    assign o_out_data.motor_front_right = w_pulse[1];
    assign o_out_data.motor_back_left   = w_pulse[2];
    assign o_out_data.motor_back_right  = w_pulse[3];
    assign o_out_data.armed_now         = r_flg4.armed;
    assign o_out_data.clear_integrators = r_flg4.clr;

endmodule
